/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list editor.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int ACT_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [POS_W-1:0]        first_position;
        logic [POS_W-1:0]        last_position;
        logic signed [VAL_W-1:0] value;
    } ple_item_t;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
    } ple_res_t;

endpackage

/* rtl/ple_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel: one edit item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface ple_req_if import ple_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        first_position;
    logic [POS_W-1:0]        last_position;
    logic signed [VAL_W-1:0] value;

    modport source (
        output valid,
        output action,
        output first_position,
        output last_position,
        output value,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  first_position,
        input  last_position,
        input  value,
        output ready
    );

endinterface

/* rtl/ple_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel: one result item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface ple_rsp_if import ple_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;

    modport source (
        output valid,
        output read_value,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_value,
        input  status,
        output ready
    );

endinterface

/* rtl/positional_list_editor.sv */
`timescale 1ns / 1ps
// Insert moves each later entry up one place and remove moves each later entry
// down, one read and one write per entry; reverse swaps pairs from both ends.
// One item at a time: a new item is accepted only after the previous result has
// passed to the output register; the walk over the element store is sequential.
// A finished result is held in the output register while the next item runs.
// Reset clears the element count and control; store contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_editor
// Bounded list of signed values with append, insert, remove, reverse, query.
// ----------------------------------------------------------------------------
module positional_list_editor import ple_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    ple_item_t               item;
    ple_res_t                res;
    logic                    res_take;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic signed [VAL_W-1:0] mem_wdata, mem_rdata;
    logic [CW-1:0]           count;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [ST_W-1:0]         out_status_reg;

    assign item.action         = req.action;
    assign item.first_position = req.first_position;
    assign item.last_position  = req.last_position;
    assign item.value          = req.value;

    ple_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .res        (res),
        .res_take   (res_take),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .count      (count)
    );

    ple_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_take = res.valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_value_reg  <= res.read_value;
            out_status_reg <= res.status;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;

    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && res.valid))
        else $error("input ready while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(DEPTH))
        else $error("element count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                          count == $past(count) - CW'(1)))
        else $error("element count moved by more than one");

    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (rsp.valid && (rsp.status == ST_OK || rsp.status == ST_RANGE ||
                                    rsp.status == ST_BAD)))
        else $error("taken result not presented");

endmodule

/* rtl/ple_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_mem import ple_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic signed [VAL_W-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic signed [VAL_W-1:0]          rdata
);

    logic signed [VAL_W-1:0] mem_reg [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ple_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer: checks bounds, then walks the store step by step
// through a shared index step unit and a shared comparator.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ple_item_t                         item,
    input  logic                              item_valid,
    output logic                              item_ready,
    output ple_res_t                          res,
    input  logic                              res_take,
    output logic                              mem_we,
    output logic [$clog2(DEPTH)-1:0]          mem_waddr,
    output logic signed [VAL_W-1:0]           mem_wdata,
    output logic [$clog2(DEPTH)-1:0]          mem_raddr,
    input  logic signed [VAL_W-1:0]           mem_rdata,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOP   = 4'd1;
    localparam logic [3:0] S_SH_RD  = 4'd2;
    localparam logic [3:0] S_SH_WR  = 4'd3;
    localparam logic [3:0] S_PUT    = 4'd4;
    localparam logic [3:0] S_RM_RD  = 4'd5;
    localparam logic [3:0] S_RM_WR  = 4'd6;
    localparam logic [3:0] S_RV_RLO = 4'd7;
    localparam logic [3:0] S_RV_RHI = 4'd8;
    localparam logic [3:0] S_RV_WLO = 4'd9;
    localparam logic [3:0] S_RV_WHI = 4'd10;
    localparam logic [3:0] S_Q_RD   = 4'd11;
    localparam logic [3:0] S_Q_DAT  = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [ACT_W-1:0]        op_reg, op_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           lim_reg, lim_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] tmp_reg, tmp_next;
    logic signed [VAL_W-1:0] rd_reg, rd_next;
    logic [ST_W-1:0]         st_reg, st_next;

    logic [XW-1:0] p1x, p2x, cntx;
    logic          p1_ok, p2_ok, p_order, full;
    logic [CW-1:0] p1c, p1m, p2m;

    logic          step_dec;
    logic [CW-1:0] step_in, step_out;
    logic [CW-1:0] cmp_a, cmp_b;
    logic          gt;

    // bounds checks on the incoming item
    assign p1x     = XW'(item.first_position);
    assign p2x     = XW'(item.last_position);
    assign cntx    = XW'(count_reg);
    assign p1_ok   = (p1x != '0) && (p1x <= cntx);
    assign p2_ok   = (p2x != '0) && (p2x <= cntx);
    assign p_order = item.first_position <= item.last_position;
    assign full    = count_reg >= CW'(DEPTH);
    assign p1c     = CW'(item.first_position);
    assign p1m     = CW'(item.first_position - POS_W'(1));
    assign p2m     = CW'(item.last_position - POS_W'(1));

    // shared index step unit
    assign step_dec = (state_reg == S_SH_RD) || (state_reg == S_SH_WR) ||
                      (state_reg == S_RV_WHI);
    assign step_in  = (state_reg == S_RV_WHI) ? lim_reg : idx_reg;
    assign step_out = step_dec ? (step_in - CW'(1)) : (step_in + CW'(1));

    // shared loop comparator
    always_comb
    begin
        case (op_reg) inside
            ACT_APPEND, ACT_INSERT:
            begin
                cmp_a = idx_reg;
                cmp_b = lim_reg;
            end
            ACT_REMOVE:
            begin
                cmp_a = lim_reg;
                cmp_b = step_out;
            end
            default:
            begin
                cmp_a = lim_reg;
                cmp_b = idx_reg;
            end
        endcase
    end

    assign gt = cmp_a > cmp_b;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        val_next   = val_reg;
        tmp_next   = tmp_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next    = item.action;
                    val_next   = item.value;
                    rd_next    = '0;
                    st_next    = ST_OK;
                    state_next = S_FIN;
                    case (item.action)
                        ACT_APPEND:
                        begin
                            if (full)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                lim_next   = count_reg;
                                state_next = S_LOOP;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (full || !p1_ok)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                lim_next   = p1c;
                                state_next = S_LOOP;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!p1_ok)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = p1m;
                                lim_next   = count_reg;
                                state_next = S_LOOP;
                            end
                        end
                        ACT_REVERSE:
                        begin
                            if (!p1_ok || !p2_ok || !p_order)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = p1m;
                                lim_next   = p2m;
                                state_next = S_LOOP;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (!p1_ok)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = p1m;
                                state_next = S_Q_RD;
                            end
                        end
                        default:
                        begin
                            st_next = ST_BAD;
                        end
                    endcase
                end
            end
            S_LOOP:
            begin
                case (op_reg) inside
                    ACT_APPEND, ACT_INSERT:
                    begin
                        state_next = gt ? S_SH_RD : S_PUT;
                    end
                    ACT_REMOVE:
                    begin
                        if (gt)
                        begin
                            state_next = S_RM_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = gt ? S_RV_RLO : S_FIN;
                    end
                endcase
            end
            S_SH_RD:
            begin
                mem_raddr  = step_out[AW-1:0];
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = step_out;
                state_next = S_LOOP;
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lim_reg[AW-1:0];
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end
            S_RM_RD:
            begin
                mem_raddr  = step_out[AW-1:0];
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = step_out;
                state_next = S_LOOP;
            end
            S_RV_RLO:
            begin
                state_next = S_RV_RHI;
            end
            S_RV_RHI:
            begin
                mem_raddr  = lim_reg[AW-1:0];
                tmp_next   = mem_rdata;
                state_next = S_RV_WLO;
            end
            S_RV_WLO:
            begin
                mem_we     = 1'b1;
                idx_next   = step_out;
                state_next = S_RV_WHI;
            end
            S_RV_WHI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lim_reg[AW-1:0];
                mem_wdata  = tmp_reg;
                lim_next   = step_out;
                state_next = S_LOOP;
            end
            S_Q_RD:
            begin
                state_next = S_Q_DAT;
            end
            S_Q_DAT:
            begin
                rd_next    = mem_rdata;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        idx_reg <= idx_next;
        lim_reg <= lim_next;
        val_reg <= val_next;
        tmp_reg <= tmp_next;
        rd_reg  <= rd_next;
        st_reg  <= st_next;
    end

    assign item_ready     = state_reg == S_IDLE;
    assign res.valid      = state_reg == S_FIN;
    assign res.read_value = rd_reg;
    assign res.status     = st_reg;
    assign count          = count_reg;

endmodule

/* verif/positional_list_editor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_editor_tb
// Drives append, insert, remove, reverse, query and invalid items into the
// list editor with random gaps and output stalls. A directed table of edge
// cases runs first. Random fill, drain and churn phases follow. Every result
// item is compared in order with the table's reply or a shadow copy of the list.
// ----------------------------------------------------------------------------
module positional_list_editor_tb;
    import ple_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 250;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

    localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
    } list_reply_t;

    typedef struct {
        ple_item_t   item;
        bit          typed;
        list_reply_t reply;
    } edit_row_t;

    typedef enum {GROW, SHRINK, CHURN} phase_t;

    logic clk;
    logic rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    positional_list_editor #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [VAL_W-1:0] shadow_list [DEPTH];
    int                      shadow_len;
    list_reply_t             reply_fifo [$];
    edit_row_t               edit_rows [$];
    int                      errors;
    int                      replies_seen;
    int                      cycles;
    int                      send_burst;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // shadow of the list; updates state and returns the reply for one item
    function automatic list_reply_t apply_edit(ple_item_t e);
        list_reply_t             r;
        int                      p1;
        int                      p2;
        int                      k;
        int                      lo;
        int                      hi;
        logic signed [VAL_W-1:0] t;
        r.read_value = '0;
        r.status     = ST_OK;
        p1 = int'(e.first_position);
        p2 = int'(e.last_position);
        case (e.action)
            ACT_APPEND:
            begin
                if (shadow_len < DEPTH)
                begin
                    shadow_list[shadow_len] = e.value;
                    shadow_len++;
                end
                else
                    r.status = ST_RANGE;
            end
            ACT_INSERT:
            begin
                if (p1 >= 1 && p1 <= shadow_len && shadow_len < DEPTH)
                begin
                    for (k = shadow_len; k > p1; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p1] = e.value;
                    shadow_len++;
                end
                else
                    r.status = ST_RANGE;
            end
            ACT_REMOVE:
            begin
                if (p1 >= 1 && p1 <= shadow_len)
                begin
                    for (k = p1 - 1; k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                end
                else
                    r.status = ST_RANGE;
            end
            ACT_REVERSE:
            begin
                if (p1 >= 1 && p2 <= shadow_len && p1 <= p2)
                begin
                    lo = p1 - 1;
                    hi = p2 - 1;
                    while (lo < hi)
                    begin
                        t               = shadow_list[lo];
                        shadow_list[lo] = shadow_list[hi];
                        shadow_list[hi] = t;
                        lo++;
                        hi--;
                    end
                end
                else
                    r.status = ST_RANGE;
            end
            ACT_QUERY:
            begin
                if (p1 >= 1 && p1 <= shadow_len)
                    r.read_value = shadow_list[p1-1];
                else
                    r.status = ST_RANGE;
            end
            default:
                r.status = ST_BAD;
        endcase
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int len);
        int r;
        r = $urandom_range(0, 99);
        if (len > 0 && r < 80)
            return POS_W'($urandom_range(1, len));
        else if (r < 88)
            return POS_W'(len + 1);
        else if (r < 93)
            return '0;
        else
            return POS_W'($urandom_range(0, 127));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 31))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [ACT_W-1:0] act, input int p1, input int p2,
                           input logic signed [VAL_W-1:0] v, input bit typed,
                           input logic signed [VAL_W-1:0] rd, input logic [ST_W-1:0] st);
        edit_row_t row;
        row.item.action         = act;
        row.item.first_position = POS_W'(p1);
        row.item.last_position  = POS_W'(p2);
        row.item.value          = v;
        row.typed               = typed;
        row.reply.read_value    = rd;
        row.reply.status        = st;
        edit_rows.push_back(row);
    endtask

    // offer one item, wait for acceptance, then record its expected reply
    task automatic issue_edit(input ple_item_t e, input bit typed, input list_reply_t given);
        int          gap;
        list_reply_t r;
        if (send_burst > 0)
        begin
            send_burst--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0)
                send_burst = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.action         <= e.action;
        req_ch.first_position <= e.first_position;
        req_ch.last_position  <= e.last_position;
        req_ch.value          <= e.value;
        do @(posedge clk); while (!req_ch.ready);
        r = apply_edit(e);
        reply_fifo.push_back(typed ? given : r);
    endtask

    initial
    begin
        ple_item_t   e;
        list_reply_t none;
        phase_t      phase;
        int          extra;
        int          churn_left;
        int          r;
        int          n;

        errors       = 0;
        replies_seen = 0;
        cycles       = 0;
        send_burst   = 0;
        shadow_len   = 0;
        none.read_value = '0;
        none.status     = ST_OK;

        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.action         <= '0;
        req_ch.first_position <= '0;
        req_ch.last_position  <= '0;
        req_ch.value          <= '0;
        rsp_ch.ready          <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, invalid codes, extremes, bounds
        add_row(ACT_QUERY,   1,   0,   0,             1, 0,             ST_RANGE);
        add_row(ACT_REMOVE,  1,   0,   0,             1, 0,             ST_RANGE);
        add_row(ACT_REVERSE, 1,   1,   0,             1, 0,             ST_RANGE);
        add_row(ACT_INSERT,  0,   0,   9,             1, 0,             ST_RANGE);
        add_row(ACT_RSVD5,   1,   1,   1,             1, 0,             ST_BAD);
        add_row(ACT_RSVD7,   127, 127, -1,            1, 0,             ST_BAD);
        add_row(ACT_APPEND,  0,   0,   32'sh7fffffff, 1, 0,             ST_OK);
        add_row(ACT_APPEND,  127, 127, 32'sh80000000, 1, 0,             ST_OK);
        add_row(ACT_APPEND,  0,   0,   -1,            1, 0,             ST_OK);
        add_row(ACT_QUERY,   1,   0,   0,             1, 32'sh7fffffff, ST_OK);
        add_row(ACT_QUERY,   3,   0,   0,             1, -1,            ST_OK);
        add_row(ACT_QUERY,   4,   0,   0,             1, 0,             ST_RANGE);
        add_row(ACT_QUERY,   0,   0,   0,             1, 0,             ST_RANGE);
        add_row(ACT_INSERT,  1,   0,   0,             1, 0,             ST_OK);
        add_row(ACT_INSERT,  4,   0,   5,             1, 0,             ST_OK);
        add_row(ACT_INSERT,  6,   0,   7,             1, 0,             ST_RANGE);
        add_row(ACT_REVERSE, 1,   5,   0,             0, 0,             ST_OK);
        add_row(ACT_QUERY,   1,   0,   0,             0, 0,             ST_OK);
        add_row(ACT_REVERSE, 2,   2,   0,             1, 0,             ST_OK);
        add_row(ACT_REVERSE, 3,   2,   0,             1, 0,             ST_RANGE);
        add_row(ACT_REVERSE, 1,   6,   0,             1, 0,             ST_RANGE);
        add_row(ACT_REMOVE,  5,   0,   0,             1, 0,             ST_OK);
        add_row(ACT_REMOVE,  0,   0,   0,             1, 0,             ST_RANGE);
        add_row(ACT_QUERY,   127, 0,   0,             1, 0,             ST_RANGE);
        add_row(ACT_RSVD6,   64,  64,  0,             1, 0,             ST_BAD);

        foreach (edit_rows[i])
            issue_edit(edit_rows[i].item, edit_rows[i].typed, edit_rows[i].reply);

        // fill to full, drain to empty, churn in between
        phase      = GROW;
        extra      = 0;
        churn_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            e.first_position = pick_pos(shadow_len);
            e.last_position  = POS_W'($urandom_range(0, 127));
            e.value          = pick_value();
            if (r < 4)
                e.action = ACT_RSVD5 + ACT_W'($urandom_range(0, ACT_RSVD7 - ACT_RSVD5));
            else
            begin
                case (phase)
                    GROW:
                        e.action = (r < 55) ? ACT_APPEND : (r < 80) ? ACT_INSERT :
                                   (r < 88) ? ACT_QUERY  : (r < 94) ? ACT_REVERSE : ACT_REMOVE;
                    SHRINK:
                        e.action = (r < 55) ? ACT_REMOVE  : (r < 70) ? ACT_QUERY  :
                                   (r < 82) ? ACT_REVERSE : (r < 90) ? ACT_INSERT : ACT_APPEND;
                    default:
                        e.action = (r < 20) ? ACT_APPEND  : (r < 40) ? ACT_INSERT :
                                   (r < 60) ? ACT_REMOVE  : (r < 75) ? ACT_REVERSE : ACT_QUERY;
                endcase
            end
            if (e.action == ACT_REVERSE)
            begin
                if (e.first_position >= 1 && e.first_position <= shadow_len
                    && $urandom_range(0, 99) < 85)
                    e.last_position = POS_W'($urandom_range(e.first_position, shadow_len));
                else
                    e.last_position = pick_pos(shadow_len);
            end
            issue_edit(e, 1'b0, none);

            case (phase)
                GROW:
                begin
                    if (shadow_len == DEPTH)
                        extra++;
                    if (extra >= 4)
                    begin
                        phase = SHRINK;
                        extra = 0;
                    end
                end
                SHRINK:
                begin
                    if (shadow_len == 0)
                        extra++;
                    if (extra >= 3)
                    begin
                        phase      = CHURN;
                        extra      = 0;
                        churn_left = $urandom_range(30, 80);
                    end
                end
                default:
                begin
                    churn_left--;
                    if (churn_left <= 0)
                        phase = GROW;
                end
            endcase
        end
        req_ch.valid <= 1'b0;

        while (reply_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, one long hold-off, in-order compare
    initial
    begin
        int          stall;
        int          burst;
        bit          held;
        list_reply_t want;
        burst = 0;
        held  = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!held && replies_seen >= HOLD_AFTER)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else if (burst > 0)
            begin
                burst--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 12);
                if ($urandom_range(0, 15) == 0)
                    burst = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);

            replies_seen++;
            if (reply_fifo.size() == 0)
            begin
                $error("unexpected result item: read_value %0d status %0d",
                       rsp_ch.read_value, rsp_ch.status);
                errors++;
            end
            else
            begin
                want = reply_fifo.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, rsp_ch.read_value);
                    errors++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    errors++;
                end
            end
        end
    end

endmodule

/* positional_list_editor.f */
rtl/ple_pkg.sv
rtl/ple_req_if.sv
rtl/ple_rsp_if.sv
rtl/ple_mem.sv
rtl/ple_ctrl.sv
rtl/positional_list_editor.sv
verif/positional_list_editor_tb.sv
